FILE: rtl/sawarq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sawarq_pkg;

  localparam int QueueDepth = 8;
  localparam int QueueIdxW  = $clog2(QueueDepth);
  localparam int TagW       = 8;
  localparam int MaxResults = 3;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SEND = 2'd1,
    CMD_RECV = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_TX_DATA  = 3'd2,
    KIND_TX_ACK   = 3'd3,
    KIND_DELIVER  = 3'd4,
    KIND_ACKED    = 3'd5,
    KIND_FAILED   = 3'd6,
    KIND_SPARE    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    REG_LOCAL_SESSION = 3'd0,
    REG_INIT_PEER     = 3'd1,
    REG_INIT_VALID    = 3'd2,
    REG_ACK_TIMEOUT   = 3'd3,
    REG_MAX_RETRIES   = 3'd4,
    REG_MAX_LEN       = 3'd5,
    REG_ACK_TYPE      = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_t;

  localparam logic [15:0] SessionReset = 16'd1;
  localparam logic [15:0] TimeoutReset = 16'd300;
  localparam logic [2:0]  RetriesReset = 3'd3;
  localparam logic [7:0]  MaxLenReset  = 8'd250;
  localparam logic [2:0]  RetryCap     = 3'd6;
  localparam logic [2:0]  AttemptsMax  = 3'd7;

  typedef struct packed {
    logic [3:0]      ptype;
    logic [15:0]     seq;
    logic [TagW-1:0] tag;
  } qentry_t;

  typedef struct packed {
    kind_t           kind;
    logic [47:0]     dest;
    logic [3:0]      ptype;
    logic [15:0]     seq;
    logic [15:0]     sess;
    logic [15:0]     aseq;
    logic [15:0]     asess;
    logic [TagW-1:0] tag;
    logic [15:0]     rtt;
    logic [2:0]      retry;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/stop_and_wait_arq_link.sv
`timescale 1ns / 1ps
`default_nettype none
// Stop-and-wait ARQ link engine.
// Results of an item are registered and appear the cycle after it is accepted,
// one beat per cycle while out_ready is high, up to three beats per item.
// Throughput: one item per cycle while items yield at most one beat and out_ready
// is high; else one item per result beat (the result group register drains first).
// Reset (rst, synchronous): clears timers, queue pointers, flight and dedup state,
// and returns every config register to its default.
module stop_and_wait_arq_link (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [47:0]              cfg_data,
  // input items
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               cmd,
  input  wire logic [3:0]               pkt_type,
  input  wire logic [15:0]              sequence_req,
  input  wire logic [15:0]              session,
  input  wire logic [15:0]              ack_sequence,
  input  wire logic [15:0]              ack_session,
  input  wire logic [47:0]              sender_address,
  input  wire logic [sawarq_pkg::TagW-1:0] payload_tag,
  input  wire logic [7:0]               payload_length,
  // results
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [2:0]                    kind,
  output logic                          last,
  output logic [47:0]                   dest_address,
  output logic [3:0]                    out_type,
  output logic [15:0]                   out_sequence,
  output logic [15:0]                   out_session,
  output logic [15:0]                   out_ack_sequence,
  output logic [15:0]                   out_ack_session,
  output logic [sawarq_pkg::TagW-1:0]   out_tag,
  output logic [15:0]                   round_trip_ms,
  output logic [2:0]                    retry_count
);
  import sawarq_pkg::*;

  // Config. The initial peer registers only matter at reset, and reset
  // restores them to their defaults at the same time, so the peer state
  // resets to "unknown" and writes to those two indexes are absorbed.
  logic [15:0] local_session;
  logic [15:0] ack_wait_ms;
  logic [2:0]  retry_max;
  logic [7:0]  max_payload_len;
  logic [3:0]  ack_type_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_session   <= SessionReset;
      ack_wait_ms     <= TimeoutReset;
      retry_max       <= RetriesReset;
      max_payload_len <= MaxLenReset;
      ack_type_code   <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LOCAL_SESSION: local_session   <= cfg_data[15:0];
        REG_ACK_TIMEOUT:   ack_wait_ms     <= cfg_data[15:0];
        REG_MAX_RETRIES:   retry_max       <= cfg_data[2:0];
        REG_MAX_LEN:       max_payload_len <= cfg_data[7:0];
        REG_ACK_TYPE:      ack_type_code   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Link state
  logic [31:0]          now_ms, now_ms_next;
  logic [15:0]          next_seq, next_seq_next;
  logic [47:0]          peer_dest, peer_dest_next;
  logic                 peer_known, peer_known_next;
  logic                 pend_active, pend_active_next;
  qentry_t              pend, pend_next;
  logic [2:0]           pend_attempts, pend_attempts_next;
  logic [31:0]          first_sent_ms, first_sent_ms_next;
  logic [31:0]          last_sent_ms, last_sent_ms_next;
  logic [15:0]          deliv_seq, deliv_seq_next;
  logic [15:0]          deliv_session, deliv_session_next;
  logic                 deliv_valid, deliv_valid_next;
  logic [QueueIdxW-1:0] tx_head, tx_head_next;
  logic [QueueIdxW-1:0] tx_tail, tx_tail_next;
  qentry_t              tx_queue [QueueDepth];

  // Result group: all beats of one item, drained one per cycle while out_ready is high
  result_t     grp [MaxResults];
  result_t     grp_next [MaxResults];
  logic [1:0]  grp_cnt, grp_cnt_next;
  logic [1:0]  grp_idx;

  logic in_fire, out_fire, drain_done;
  logic q_wr;
  qentry_t q_wdata, q_head;
  logic [2:0] limit;
  logic [31:0] rtt_full;
  logic [QueueIdxW-1:0] head_inc;

  assign out_valid  = (grp_cnt != 2'd0);
  assign out_fire   = out_valid && out_ready;
  assign drain_done = out_fire && (grp_idx == grp_cnt - 2'd1);
  assign in_ready   = !out_valid || drain_done;
  assign in_fire    = in_valid && in_ready;
  assign limit      = (retry_max > RetryCap) ? RetryCap : retry_max;
  assign head_inc   = tx_head + 1'b1;

  always_comb begin
    result_t r;
    logic    rej;
    r = '0;
    rej = 1'b0;
    now_ms_next        = now_ms;
    next_seq_next      = next_seq;
    peer_dest_next     = peer_dest;
    peer_known_next    = peer_known;
    pend_active_next   = pend_active;
    pend_next          = pend;
    pend_attempts_next = pend_attempts;
    first_sent_ms_next = first_sent_ms;
    last_sent_ms_next  = last_sent_ms;
    deliv_seq_next     = deliv_seq;
    deliv_session_next = deliv_session;
    deliv_valid_next   = deliv_valid;
    tx_head_next       = tx_head;
    tx_tail_next       = tx_tail;
    q_wr               = 1'b0;
    q_wdata            = '{ptype: pkt_type, seq: next_seq, tag: payload_tag};
    rtt_full           = '0;
    for (int i = 0; i < MaxResults; i++) grp_next[i] = '0;
    grp_cnt_next       = 2'd0;

    // item's own action
    case (cmd_t'(cmd))
      CMD_TICK: now_ms_next = now_ms + 32'd1;
      CMD_SEND: begin
        rej = (pkt_type == ack_type_code) || (payload_length > max_payload_len)
              || (head_inc == tx_tail);
        r = '0;
        r.ptype = pkt_type;
        r.tag   = payload_tag;
        if (rej) begin
          r.kind = KIND_REJECTED;
        end else begin
          r.kind = KIND_ACCEPTED;
          r.seq  = next_seq;
          r.sess = local_session;
          q_wr = 1'b1;
          tx_head_next = head_inc;
          next_seq_next = next_seq + 16'd1;
        end
        grp_next[grp_cnt_next] = r;
        grp_cnt_next = grp_cnt_next + 2'd1;
      end
      CMD_RECV: begin
        peer_dest_next  = sender_address;
        peer_known_next = 1'b1;
        if (pkt_type == ack_type_code) begin
          if (pend_active && ack_sequence == pend.seq && ack_session == local_session) begin
            rtt_full = now_ms - first_sent_ms;
            r = '0;
            r.kind  = KIND_ACKED;
            r.ptype = pend.ptype;
            r.seq   = pend.seq;
            r.sess  = local_session;
            r.tag   = pend.tag;
            r.rtt   = (rtt_full > 32'hFFFF) ? 16'hFFFF : rtt_full[15:0];
            r.retry = (pend_attempts != 3'd0) ? pend_attempts - 3'd1 : 3'd0;
            grp_next[grp_cnt_next] = r;
            grp_cnt_next = grp_cnt_next + 2'd1;
            pend_active_next = 1'b0;
          end
        end else begin
          r = '0;
          r.kind  = KIND_TX_ACK;
          r.dest  = sender_address;
          r.ptype = ack_type_code;
          r.seq   = next_seq;
          r.sess  = local_session;
          r.aseq  = sequence_req;
          r.asess = session;
          grp_next[grp_cnt_next] = r;
          grp_cnt_next = grp_cnt_next + 2'd1;
          next_seq_next = next_seq + 16'd1;
          if (!(deliv_valid && session == deliv_session && sequence_req == deliv_seq)) begin
            r = '0;
            r.kind  = KIND_DELIVER;
            r.ptype = pkt_type;
            r.seq   = sequence_req;
            r.sess  = session;
            r.tag   = payload_tag;
            grp_next[grp_cnt_next] = r;
            grp_cnt_next = grp_cnt_next + 2'd1;
            deliv_seq_next     = sequence_req;
            deliv_session_next = session;
            deliv_valid_next   = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // start the head entry when nothing is in flight and the queue holds one, unless cmd is CMD_NONE
    if (cmd_t'(cmd) != CMD_NONE && !pend_active_next && tx_tail != tx_head_next) begin
      pend_next          = q_head;
      tx_tail_next       = tx_tail + 1'b1;
      pend_active_next   = 1'b1;
      pend_attempts_next = 3'd0;
      first_sent_ms_next = now_ms_next;
      if (peer_known_next) begin
        r = '0;
        r.kind  = KIND_TX_DATA;
        r.dest  = peer_dest_next;
        r.ptype = q_head.ptype;
        r.seq   = q_head.seq;
        r.sess  = local_session;
        r.tag   = q_head.tag;
        grp_next[grp_cnt_next] = r;
        grp_cnt_next = grp_cnt_next + 2'd1;
        pend_attempts_next = 3'd1;
        last_sent_ms_next  = now_ms_next;
      end
    end

    // timeout check, ticks only
    if (cmd_t'(cmd) == CMD_TICK && pend_active_next &&
        (now_ms_next - last_sent_ms_next) >= {16'd0, ack_wait_ms}) begin
      if (pend_attempts_next <= limit) begin
        if (peer_known_next) begin
          r = '0;
          r.kind  = KIND_TX_DATA;
          r.dest  = peer_dest_next;
          r.ptype = pend_next.ptype;
          r.seq   = pend_next.seq;
          r.sess  = local_session;
          r.tag   = pend_next.tag;
          grp_next[grp_cnt_next] = r;
          grp_cnt_next = grp_cnt_next + 2'd1;
          if (pend_attempts_next < AttemptsMax)
            pend_attempts_next = pend_attempts_next + 3'd1;
          last_sent_ms_next = now_ms_next;
        end
      end else begin
        r = '0;
        r.kind  = KIND_FAILED;
        r.ptype = pend_next.ptype;
        r.seq   = pend_next.seq;
        r.sess  = local_session;
        r.tag   = pend_next.tag;
        r.retry = pend_attempts_next - 3'd1;
        grp_next[grp_cnt_next] = r;
        grp_cnt_next = grp_cnt_next + 2'd1;
        pend_active_next = 1'b0;
      end
    end
  end

  // head entry, with bypass of the entry written by this very item
  assign q_head = (q_wr && tx_tail == tx_head) ? q_wdata : tx_queue[tx_tail];

  always_ff @(posedge clk) begin
    if (in_fire && q_wr) tx_queue[tx_head] <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms        <= '0;
      next_seq      <= 16'd1;
      peer_dest     <= '0;
      peer_known    <= 1'b0;
      pend_active   <= 1'b0;
      pend          <= '0;
      pend_attempts <= '0;
      first_sent_ms <= '0;
      last_sent_ms  <= '0;
      deliv_seq     <= '0;
      deliv_session <= '0;
      deliv_valid   <= 1'b0;
      tx_head       <= '0;
      tx_tail       <= '0;
    end else if (in_fire) begin
      now_ms        <= now_ms_next;
      next_seq      <= next_seq_next;
      peer_dest     <= peer_dest_next;
      peer_known    <= peer_known_next;
      pend_active   <= pend_active_next;
      pend          <= pend_next;
      pend_attempts <= pend_attempts_next;
      first_sent_ms <= first_sent_ms_next;
      last_sent_ms  <= last_sent_ms_next;
      deliv_seq     <= deliv_seq_next;
      deliv_session <= deliv_session_next;
      deliv_valid   <= deliv_valid_next;
      tx_head       <= tx_head_next;
      tx_tail       <= tx_tail_next;
    end
  end

  // result group register
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_cnt <= '0;
      grp_idx <= '0;
    end else if (in_fire) begin
      grp_cnt <= grp_cnt_next;
      grp_idx <= '0;
    end else if (drain_done) begin
      grp_cnt <= '0;
      grp_idx <= '0;
    end else if (out_fire) begin
      grp_idx <= grp_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MaxResults; i++) grp[i] <= grp_next[i];
    end
  end

  result_t cur;
  assign cur              = grp[grp_idx];
  assign kind             = cur.kind;
  assign last             = (grp_idx == grp_cnt - 2'd1);
  assign dest_address     = cur.dest;
  assign out_type         = cur.ptype;
  assign out_sequence     = cur.seq;
  assign out_session      = cur.sess;
  assign out_ack_sequence = cur.aseq;
  assign out_ack_session  = cur.asess;
  assign out_tag          = cur.tag;
  assign round_trip_ms    = cur.rtt;
  assign retry_count      = cur.retry;

endmodule
`default_nettype wire

FILE: sim/tb_stop_and_wait_arq_link.sv
`timescale 1ns / 1ps
module tb_stop_and_wait_arq_link;
  import sawarq_pkg::*;

  // one input beat as the sender sees it
  typedef struct {
    cmd_t        cmd;
    logic [3:0]  ptype;
    logic [15:0] seq;
    logic [15:0] sess;
    logic [15:0] aseq;
    logic [15:0] asess;
    logic [47:0] addr;
    logic [7:0]  tag;
    logic [7:0]  len;
  } link_item_t;

  // one result beat as predicted
  typedef struct {
    kind_t       kind;
    logic        lst;
    logic [47:0] dest;
    logic [3:0]  ptype;
    logic [15:0] seq;
    logic [15:0] sess;
    logic [15:0] aseq;
    logic [15:0] asess;
    logic [7:0]  tag;
    logic [15:0] rtt;
    logic [2:0]  retry;
  } link_beat_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] cmd;
  logic [3:0] pkt_type;
  logic [15:0] sequence_req, session, ack_sequence, ack_session;
  logic [47:0] sender_address;
  logic [7:0] payload_tag, payload_length;
  logic out_valid, out_ready;
  logic [2:0] kind;
  logic last;
  logic [47:0] dest_address;
  logic [3:0] out_type;
  logic [15:0] out_sequence, out_session, out_ack_sequence, out_ack_session;
  logic [7:0] out_tag;
  logic [15:0] round_trip_ms;
  logic [2:0] retry_count;

  stop_and_wait_arq_link u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .pkt_type(pkt_type),
    .sequence_req(sequence_req), .session(session), .ack_sequence(ack_sequence),
    .ack_session(ack_session), .sender_address(sender_address),
    .payload_tag(payload_tag), .payload_length(payload_length),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last),
    .dest_address(dest_address), .out_type(out_type), .out_sequence(out_sequence),
    .out_session(out_session), .out_ack_sequence(out_ack_sequence),
    .out_ack_session(out_ack_session), .out_tag(out_tag),
    .round_trip_ms(round_trip_ms), .retry_count(retry_count)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------
  // Link model: register copies and protocol state, stepped once per
  // accepted input beat.
  // ---------------------------------------------------------------------
  logic [15:0] c_session = SessionReset;
  logic [47:0] c_init_peer = '0;
  logic        c_init_valid = 1'b0;
  logic [15:0] c_timeout = TimeoutReset;
  logic [2:0]  c_retries = RetriesReset;
  logic [7:0]  c_maxlen = MaxLenReset;
  logic [3:0]  c_ack_type = 4'd0;

  logic [31:0] m_now = '0;
  logic [15:0] m_next_seq = 16'd1;
  // peer state starts unknown; the init register copies never feed it
  logic [47:0] m_peer = '0;
  logic        m_peer_known = 1'b0;
  logic        m_in_flight = 1'b0;
  logic [3:0]  m_fl_type = '0;
  logic [15:0] m_fl_seq = '0;
  logic [7:0]  m_fl_tag = '0;
  logic [2:0]  m_attempts = '0;
  logic [31:0] m_first_ms = '0, m_last_ms = '0;
  logic [15:0] m_dseq = '0, m_dsess = '0;
  logic        m_dvalid = 1'b0;
  qentry_t     m_txq [QueueDepth];
  logic [2:0]  m_head = '0, m_tail = '0;

  link_beat_t  expected_beats [$];
  link_item_t  pending_items [$];
  int          fail_cnt = 0;

  function automatic void add_beat(kind_t k, logic [47:0] d, logic [3:0] t,
                                   logic [15:0] s, logic [15:0] ss,
                                   logic [15:0] as, logic [15:0] ass,
                                   logic [7:0] g, logic [15:0] r, logic [2:0] rc);
    link_beat_t b;
    b.kind = k; b.lst = 1'b0; b.dest = d; b.ptype = t; b.seq = s; b.sess = ss;
    b.aseq = as; b.asess = ass; b.tag = g; b.rtt = r; b.retry = rc;
    expected_beats.push_back(b);
  endfunction

  function automatic void send_in_flight();
    if (!m_peer_known) return;  // no peer: nothing goes out
    add_beat(KIND_TX_DATA, m_peer, m_fl_type, m_fl_seq, c_session, 0, 0,
             m_fl_tag, 0, 0);
    if (m_attempts < AttemptsMax) m_attempts++;
    m_last_ms = m_now;
  endfunction

  function automatic void launch_next();
    if (m_in_flight || m_head == m_tail) return;
    m_fl_type = m_txq[m_tail].ptype;
    m_fl_seq = m_txq[m_tail].seq;
    m_fl_tag = m_txq[m_tail].tag;
    m_tail++;
    m_in_flight = 1'b1;
    m_attempts = '0;
    m_first_ms = m_now;
    send_in_flight();
  endfunction

  function automatic void retry_timer();
    logic [2:0] cap;
    cap = (c_retries > RetryCap) ? RetryCap : c_retries;
    if (!m_in_flight) return;
    if (m_now - m_last_ms < {16'd0, c_timeout}) return;
    if (m_attempts <= cap) send_in_flight();
    else begin
      add_beat(KIND_FAILED, 0, m_fl_type, m_fl_seq, c_session, 0, 0, m_fl_tag,
               0, m_attempts - 3'd1);
      m_in_flight = 1'b0;
    end
  endfunction

  function automatic void link_step(link_item_t it);
    int n0;
    logic [31:0] rt;
    link_beat_t b;
    n0 = expected_beats.size();
    case (it.cmd)
      CMD_TICK: begin
        m_now++;
        launch_next();
        retry_timer();
      end
      CMD_SEND: begin
        if (it.ptype == c_ack_type || it.len > c_maxlen || m_head + 3'd1 == m_tail)
          add_beat(KIND_REJECTED, 0, it.ptype, 0, 0, 0, 0, it.tag, 0, 0);
        else begin
          m_txq[m_head] = '{ptype: it.ptype, seq: m_next_seq, tag: it.tag};
          m_head++;
          add_beat(KIND_ACCEPTED, 0, it.ptype, m_next_seq, c_session, 0, 0,
                   it.tag, 0, 0);
          m_next_seq++;
        end
        launch_next();
      end
      CMD_RECV: begin
        m_peer = it.addr;
        m_peer_known = 1'b1;
        if (it.ptype == c_ack_type) begin
          if (m_in_flight && it.aseq == m_fl_seq && it.asess == c_session) begin
            rt = m_now - m_first_ms;
            if (rt > 32'hFFFF) rt = 32'hFFFF;
            add_beat(KIND_ACKED, 0, m_fl_type, m_fl_seq, c_session, 0, 0,
                     m_fl_tag, rt[15:0], (m_attempts != 0) ? m_attempts - 3'd1 : 3'd0);
            m_in_flight = 1'b0;
          end
        end else begin
          add_beat(KIND_TX_ACK, it.addr, c_ack_type, m_next_seq, c_session,
                   it.seq, it.sess, 0, 0, 0);
          m_next_seq++;
          // duplicate of the last delivered packet is acked but not delivered
          if (!(m_dvalid && it.sess == m_dsess && it.seq == m_dseq)) begin
            add_beat(KIND_DELIVER, 0, it.ptype, it.seq, it.sess, 0, 0, it.tag, 0, 0);
            m_dseq = it.seq;
            m_dsess = it.sess;
            m_dvalid = 1'b1;
          end
        end
        launch_next();
      end
      default: ;  // unused command code: ignored
    endcase
    if (expected_beats.size() > n0) begin
      b = expected_beats[expected_beats.size()-1];
      b.lst = 1'b1;
      expected_beats[expected_beats.size()-1] = b;
    end
  endfunction

  function automatic void apply_reg(reg_idx_t idx, logic [47:0] v);
    case (idx)
      REG_LOCAL_SESSION: c_session = v[15:0];
      REG_INIT_PEER:     c_init_peer = v;
      REG_INIT_VALID:    c_init_valid = v[0];
      REG_ACK_TIMEOUT:   c_timeout = v[15:0];
      REG_MAX_RETRIES:   c_retries = v[2:0];
      REG_MAX_LEN:       c_maxlen = v[7:0];
      REG_ACK_TYPE:      c_ack_type = v[3:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sender: drives beats from pending_items in bursts with random gaps.
  // ---------------------------------------------------------------------
  link_item_t cur_item;
  logic in_taken = 1'b0;
  logic hold_send = 1'b0;
  int burst_left = 0, gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // beat still waiting for ready: hold it
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (!hold_send && pending_items.size() > 0) begin
      cur_item = pending_items.pop_front();
      cmd <= cur_item.cmd;
      pkt_type <= cur_item.ptype;
      sequence_req <= cur_item.seq;
      session <= cur_item.sess;
      ack_sequence <= cur_item.aseq;
      ack_session <= cur_item.asess;
      sender_address <= cur_item.addr;
      payload_tag <= cur_item.tag;
      payload_length <= cur_item.len;
      in_valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                               : $urandom_range(0, 3);
      end
    end else begin
      in_valid <= 1'b0;
    end
    in_taken = 1'b0;
  end

  // Receiver: ready pattern switches mode every so often.
  int rdy_cnt = 0, rdy_mode = 0;
  always @(negedge clk) begin
    rdy_cnt++;
    if (rdy_cnt % 97 == 0) rdy_mode = $urandom_range(0, 3);
    case (rdy_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (rdy_cnt % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // ---------------------------------------------------------------------
  // Monitor: input acceptance steps the model, result beats are checked.
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    link_beat_t e;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        link_step(cur_item);
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat, kind %0d", kind);
          fail_cnt++;
        end else begin
          e = expected_beats.pop_front();
          check_field("kind", e.kind, kind);
          check_field("last", e.lst, last);
          check_field("dest_address", e.dest, dest_address);
          check_field("out_type", e.ptype, out_type);
          check_field("out_sequence", e.seq, out_sequence);
          check_field("out_session", e.sess, out_session);
          check_field("out_ack_sequence", e.aseq, out_ack_sequence);
          check_field("out_ack_session", e.asess, out_ack_session);
          check_field("out_tag", e.tag, out_tag);
          check_field("round_trip_ms", e.rtt, round_trip_ms);
          check_field("retry_count", e.retry, retry_count);
        end
      end
    end
  end

  // watchdog: reports fail and stops if the run has not finished by the cycle limit
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 60000) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic link_item_t make_item(cmd_t c, logic [3:0] t, logic [15:0] s,
                                           logic [15:0] ss, logic [15:0] as,
                                           logic [15:0] ass, logic [47:0] a,
                                           logic [7:0] g, logic [7:0] l);
    link_item_t it;
    it.cmd = c; it.ptype = t; it.seq = s; it.sess = ss; it.aseq = as;
    it.asess = ass; it.addr = a; it.tag = g; it.len = l;
    return it;
  endfunction

  // keep the queue short so random picks see fresh link state
  task automatic push_item(link_item_t it);
    while (pending_items.size() >= 2) @(negedge clk);
    pending_items.push_back(it);
  endtask

  function automatic logic [47:0] rand_addr();
    return {16'($urandom_range(0, 65535)), 32'($urandom())};
  endfunction

  function automatic link_item_t rand_item();
    link_item_t it;
    int r;
    it = make_item(CMD_TICK, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), rand_addr(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 4) it.cmd = CMD_NONE;
    else if (r < 40) it.cmd = CMD_TICK;
    else if (r < 65) begin
      it.cmd = CMD_SEND;
      if ($urandom_range(0, 4) != 0) it.len = 8'($urandom_range(0, c_maxlen));
    end else begin
      it.cmd = CMD_RECV;
      if (m_peer_known && $urandom_range(0, 3) != 0) it.addr = m_peer;
      if ($urandom_range(0, 1) == 0) begin
        // ack, mostly for the packet in flight
        it.ptype = c_ack_type;
        if ($urandom_range(0, 3) != 0) it.aseq = m_fl_seq;
        if ($urandom_range(0, 3) != 0) it.asess = c_session;
      end else if ($urandom_range(0, 4) < 2) begin
        it.seq = m_dseq;  // likely duplicate
        it.sess = m_dsess;
      end
    end
    return it;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [47:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sampled at the rising edge, where the sender's signals are settled
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) push_item(rand_item());
  endtask

  task automatic setup(logic [15:0] sess, logic [15:0] tmo, logic [2:0] rtr,
                       logic [7:0] mlen, logic [3:0] atype);
    wait_idle();
    write_reg(REG_LOCAL_SESSION, sess);
    write_reg(REG_ACK_TIMEOUT, tmo);
    write_reg(REG_MAX_RETRIES, rtr);
    write_reg(REG_MAX_LEN, mlen);
    write_reg(REG_ACK_TYPE, atype);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; out_ready = 1'b0;
    cmd = '0; pkt_type = '0; sequence_req = '0; session = '0;
    ack_sequence = '0; ack_session = '0; sender_address = '0;
    payload_tag = '0; payload_length = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset settings, no peer known yet
    push_item(make_item(CMD_NONE, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF));
    push_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    push_item(make_item(CMD_SEND, 4'd3, 0, 0, 0, 0, 0, 8'hFF, 8'd0));   // silent start
    push_item(make_item(CMD_SEND, 4'd0, 0, 0, 0, 0, 0, 8'h11, 8'd5));   // type is ack
    push_item(make_item(CMD_SEND, 4'hF, 0, 0, 0, 0, 0, 8'h22, 8'd251)); // too long
    push_item(make_item(CMD_SEND, 4'hF, 0, 0, 0, 0, 0, 8'h00, 8'd250));
    push_item(make_item(CMD_RECV, 4'd7, 16'hFFFF, 16'hFFFF, 0, 0,
                        48'hFFFF_FFFF_FFFF, 8'hAA, 0));
    push_item(make_item(CMD_RECV, 4'd7, 16'hFFFF, 16'hFFFF, 0, 0,
                        48'hFFFF_FFFF_FFFF, 8'h55, 0));                 // duplicate
    push_item(make_item(CMD_RECV, 4'd0, 0, 0, 16'd5, 16'd1,
                        48'h1234_5678_9ABC, 0, 0));                     // stray ack
    push_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    // ack before any transmission, then next packet launches
    push_item(make_item(CMD_RECV, 4'd0, 0, 0, 16'd1, 16'd1,
                        48'h1234_5678_9ABC, 0, 0));
    push_item(make_item(CMD_RECV, 4'd0, 0, 0, 16'd2, 16'd1,
                        48'h1234_5678_9ABC, 0, 0));
    for (int i = 0; i < 9; i++)
      push_item(make_item(CMD_SEND, 4'(i + 1), 0, 0, 0, 0, 0, 8'(i), 8'(i * 20)));
    run_random(15);

    // pause until every outstanding result has drained
    hold_send = 1'b1;
    while (pending_items.size() != 0 && (expected_beats.size() != 0 || in_valid))
      @(posedge clk);
    while (expected_beats.size() != 0 || in_valid) @(posedge clk);
    @(negedge clk);
    hold_send = 1'b0;
    run_random(5);

    // extremes: zero timeout, no retries, zero max length
    setup(16'hFFFF, 16'd0, 3'd0, 8'd0, 4'hF);
    write_reg(REG_INIT_PEER, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_INIT_VALID, 1'b1);
    run_random(15);

    setup(16'h5A3C, 16'd2, 3'd6, 8'd255, 4'd5);
    write_reg(REG_INIT_PEER, 48'h0);
    write_reg(REG_INIT_VALID, 1'b0);
    run_random(15);

    // retry limit above cap, session 1
    setup(16'd1, 16'd1, 3'd7, 8'd128, 4'd0);
    run_random(15);

    setup(16'h0F0F, 16'd3, 3'd2, 8'd60, 4'd8);
    run_random(20);

    wait_idle();
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sawarq_pkg.sv
rtl/stop_and_wait_arq_link.sv
sim/tb_stop_and_wait_arq_link.sv
